>>> hdl/isp_fpl_pkg.sv
// ----------------------------------------------------------------------------
// isp_fpl_pkg
// Shared types, command codes and the microcode table of the flash page
// loader.
// ----------------------------------------------------------------------------
package isp_fpl_pkg;

  localparam logic [7:0] OP_LOAD_LOW   = 8'h40;
  localparam logic [7:0] OP_LOAD_HIGH  = 8'h48;
  localparam logic [7:0] OP_WRITE_PAGE = 8'h4C;
  localparam logic [7:0] PAD_BYTE      = 8'hFF;

  // Microcode addresses.
  typedef enum logic [2:0] {
    STEP_FETCH     = 3'd0,
    STEP_LOAD      = 3'd1,
    STEP_WRITE     = 3'd2,
    STEP_END       = 3'd3,
    STEP_PAD       = 3'd4,
    STEP_WRITE_END = 3'd5,
    STEP_CLEAR     = 3'd6,
    STEP_SPARE     = 3'd7
  } step_t;

  typedef enum logic {
    OPS_LOAD  = 1'b0,
    OPS_WRITE = 1'b1
  } op_sel_t;

  typedef enum logic [1:0] {
    LAST_NEVER    = 2'd0,
    LAST_ALWAYS   = 2'd1,
    LAST_NOT_FULL = 2'd2
  } last_sel_t;

  typedef enum logic [2:0] {
    COND_NEVER    = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_KIND_END = 3'd2,
    COND_IDLE     = 3'd3,
    COND_NOT_FULL = 3'd4
  } cond_t;

  // One control word per microcode step.
  typedef struct packed {
    logic      accept;   // wait for and take an input word
    logic      emit;     // issue one command word
    op_sel_t   op;
    logic      pad;      // load data is the pad byte
    last_sel_t last_sel;
    logic      clear;    // return the loader state to reset
    cond_t     cond;
    step_t     target;
  } ucode_t;

  // Control handed from the sequencer to the datapath.
  typedef struct packed {
    ucode_t cw;
    logic   go;          // the current step completes this cycle
  } ctl_t;

  // Status handed from the datapath to the sequencer.
  typedef struct packed {
    logic full;          // a load now would complete the page
    logic open;          // bytes loaded since the last commit
    logic out_free;      // the output register can take a word
  } status_t;

  function automatic ucode_t ucode(input step_t s);
    ucode_t cw;
    cw = '{accept: 1'b0, emit: 1'b0, op: OPS_LOAD, pad: 1'b0,
           last_sel: LAST_NEVER, clear: 1'b0, cond: COND_NEVER,
           target: STEP_FETCH};
    unique case (s)
      STEP_FETCH: begin
        cw.accept = 1'b1;
        cw.cond   = COND_KIND_END;
        cw.target = STEP_END;
      end
      STEP_LOAD: begin
        cw.emit     = 1'b1;
        cw.last_sel = LAST_NOT_FULL;
        cw.cond     = COND_NOT_FULL;
        cw.target   = STEP_FETCH;
      end
      STEP_WRITE: begin
        cw.emit     = 1'b1;
        cw.op       = OPS_WRITE;
        cw.last_sel = LAST_ALWAYS;
        cw.cond     = COND_ALWAYS;
        cw.target   = STEP_FETCH;
      end
      STEP_END: begin
        cw.cond   = COND_IDLE;
        cw.target = STEP_CLEAR;
      end
      STEP_PAD: begin
        cw.emit   = 1'b1;
        cw.pad    = 1'b1;
        cw.cond   = COND_NOT_FULL;
        cw.target = STEP_PAD;
      end
      STEP_WRITE_END: begin
        cw.emit     = 1'b1;
        cw.op       = OPS_WRITE;
        cw.last_sel = LAST_ALWAYS;
        cw.clear    = 1'b1;
        cw.cond     = COND_ALWAYS;
        cw.target   = STEP_FETCH;
      end
      STEP_CLEAR: begin
        cw.clear  = 1'b1;
        cw.cond   = COND_ALWAYS;
        cw.target = STEP_FETCH;
      end
      STEP_SPARE: begin
        cw.cond   = COND_ALWAYS;
        cw.target = STEP_FETCH;
      end
      default: begin
        cw.cond   = COND_ALWAYS;
        cw.target = STEP_FETCH;
      end
    endcase
    return cw;
  endfunction

endpackage

>>> hdl/isp_fpl_in_if.sv
// ----------------------------------------------------------------------------
// isp_fpl_in_if
// Image channel: one image byte or an end-of-image mark per word.
// ----------------------------------------------------------------------------
interface isp_fpl_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] image_byte;

  modport source (output valid, output kind, output image_byte, input ready);
  modport sink   (input valid, input kind, input image_byte, output ready);
endinterface

>>> hdl/isp_fpl_out_if.sv
// ----------------------------------------------------------------------------
// isp_fpl_out_if
// Command channel: one four-byte programming command per word.
// ----------------------------------------------------------------------------
interface isp_fpl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] opcode_byte;
  logic [7:0] addr_high;
  logic [7:0] addr_low;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output opcode_byte, output addr_high,
                  output addr_low, output data_byte, output last, input ready);
  modport sink   (input valid, input opcode_byte, input addr_high,
                  input addr_low, input data_byte, input last, output ready);
endinterface

>>> hdl/isp_fpl_seq.sv
// ----------------------------------------------------------------------------
// isp_fpl_seq
// Microcode sequencer: step counter, control word lookup and jumps.
// ----------------------------------------------------------------------------
module isp_fpl_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_kind,
  input  isp_fpl_pkg::status_t st,
  output isp_fpl_pkg::ctl_t    ctl
);
  import isp_fpl_pkg::*;

  step_t  pc;
  step_t  pc_next;
  ucode_t cw;
  logic   go;
  logic   take;

  assign cw = ucode(pc);
  assign go = (!cw.accept || in_valid) && (!cw.emit || st.out_free);

  always_comb begin
    unique case (cw.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_KIND_END: take = in_kind;
      COND_IDLE:     take = !st.open;
      COND_NOT_FULL: take = !st.full;
      default:       take = 1'b1;
    endcase
  end

  always_comb begin
    pc_next = pc;
    if (go) begin
      pc_next = take ? cw.target : step_t'(pc + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctl.cw = cw;
  assign ctl.go = go;

  // A clearing step always hands control back to the fetch step.
  a_clear_returns: assert property (@(posedge clk) disable iff (rst)
    (go && cw.clear) |=> (pc == STEP_FETCH))
    else $error("clearing step did not return to fetch");

  // The padding loop only leaves through the closing write-page step.
  a_pad_exit: assert property (@(posedge clk) disable iff (rst)
    (go && pc == STEP_PAD && st.full) |=> (pc == STEP_WRITE_END))
    else $error("padding loop left without closing the page");

endmodule

>>> hdl/isp_fpl_dp.sv
// ----------------------------------------------------------------------------
// isp_fpl_dp
// Loader datapath: address and page state, latched image byte and the
// command output register.
// ----------------------------------------------------------------------------
module isp_fpl_dp #(
  parameter int PAGE_WORDS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  isp_fpl_pkg::ctl_t    ctl,
  input  logic [7:0]           in_byte,
  output isp_fpl_pkg::status_t st,
  isp_fpl_out_if.source        cmd
);
  import isp_fpl_pkg::*;

  localparam int WW = $clog2(PAGE_WORDS + 1);

  logic [15:0]   word_address;
  logic [15:0]   page_start;
  logic          high_half;
  logic [WW-1:0] words_in_page;
  logic [7:0]    byte_reg;

  logic          out_valid;
  logic [7:0]    opcode_reg;
  logic [15:0]   addr_reg;
  logic [7:0]    data_reg;
  logic          last_reg;

  logic [7:0]    op_now;
  logic [15:0]   addr_now;
  logic [7:0]    data_now;
  logic          last_now;
  logic          emitting;

  assign st.full     = high_half && (words_in_page == WW'(PAGE_WORDS - 1));
  assign st.open     = high_half || (words_in_page != '0);
  assign st.out_free = !out_valid || cmd.ready;

  assign emitting = ctl.go && ctl.cw.emit;

  always_comb begin
    if (ctl.cw.op == OPS_WRITE) begin
      op_now   = OP_WRITE_PAGE;
      addr_now = page_start;
      data_now = 8'h00;
    end else begin
      op_now   = high_half ? OP_LOAD_HIGH : OP_LOAD_LOW;
      addr_now = word_address;
      data_now = ctl.cw.pad ? PAD_BYTE : byte_reg;
    end
    unique case (ctl.cw.last_sel)
      LAST_NEVER:    last_now = 1'b0;
      LAST_ALWAYS:   last_now = 1'b1;
      LAST_NOT_FULL: last_now = !st.full;
      default:       last_now = 1'b0;
    endcase
  end

  // Loader state
  always_ff @(posedge clk) begin
    if (rst) begin
      word_address  <= '0;
      page_start    <= '0;
      high_half     <= 1'b0;
      words_in_page <= '0;
    end else if (ctl.go && ctl.cw.clear) begin
      word_address  <= '0;
      page_start    <= '0;
      high_half     <= 1'b0;
      words_in_page <= '0;
    end else if (emitting && ctl.cw.op == OPS_WRITE) begin
      page_start    <= word_address;
      words_in_page <= '0;
    end else if (emitting) begin
      if (high_half) begin
        high_half     <= 1'b0;
        word_address  <= word_address + 16'd1;
        words_in_page <= words_in_page + WW'(1);
      end else begin
        high_half <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go && ctl.cw.accept) begin
      byte_reg <= in_byte;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emitting) begin
      out_valid <= 1'b1;
    end else if (cmd.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emitting) begin
      opcode_reg <= op_now;
      addr_reg   <= addr_now;
      data_reg   <= data_now;
      last_reg   <= last_now;
    end
  end

  assign cmd.valid       = out_valid;
  assign cmd.opcode_byte = opcode_reg;
  assign cmd.addr_high   = addr_reg[15:8];
  assign cmd.addr_low    = addr_reg[7:0];
  assign cmd.data_byte   = data_reg;
  assign cmd.last        = last_reg;

  a_words_bound: assert property (@(posedge clk) disable iff (rst)
    words_in_page <= WW'(PAGE_WORDS))
    else $error("page word count beyond page size");

  // A page is only committed once every word of it has been loaded.
  a_commit_full: assert property (@(posedge clk) disable iff (rst)
    (emitting && ctl.cw.op == OPS_WRITE) |->
      (words_in_page == WW'(PAGE_WORDS) && !high_half))
    else $error("write page issued for a page that is not full");

endmodule

>>> hdl/isp_flash_page_loader_core.sv
// ----------------------------------------------------------------------------
// isp_flash_page_loader_core
// Turns firmware image bytes into serial flash programming commands:
// load-low or load-high per byte, write-page per filled page, and
// padding of the open page at the end of the image.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Word carries                                   Taken when
//  -------  ---  ---------------------------------------------  -----------------
//  image    in   kind, image_byte                               valid && ready
//  cmd      out  opcode_byte, addr_high, addr_low, data_byte,   valid && ready
//                last
//
// An image byte takes a fetch step and a load step of the microcode
// sequencer, and a write step too when it completes a page, as the write
// page command has a step of its own. An end-of-image word takes the
// fetch and end steps, then one step per padding or write command, or a
// clearing step when no page is open. Each step that issues a command
// waits while the output register holds a word not yet taken; the next
// input word is only taken once the sequencer is back at its fetch step.
// Reset is synchronous and returns the addresses and page count to zero.
// ----------------------------------------------------------------------------
module isp_flash_page_loader_core #(
  parameter int PAGE_WORDS = 32
) (
  input  logic          clk,
  input  logic          rst,
  isp_fpl_in_if.sink    image,
  isp_fpl_out_if.source cmd
);
  import isp_fpl_pkg::*;

  ctl_t    ctl;
  status_t st;

  // The input is ready only during the fetch step, whose control word
  // is the only one that asks for an input word.
  assign image.ready = ctl.cw.accept;

  isp_fpl_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (image.valid),
    .in_kind  (image.kind),
    .st       (st),
    .ctl      (ctl)
  );

  isp_fpl_dp #(
    .PAGE_WORDS (PAGE_WORDS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .in_byte (image.image_byte),
    .st      (st),
    .cmd     (cmd)
  );

  // Only the fetch step takes input words, and never while issuing one.
  a_accept_no_emit: assert property (@(posedge clk) disable iff (rst)
    image.ready |-> !ctl.cw.emit)
    else $error("input taken in a command step");

endmodule
